// ===== rtl/eac_pkg.sv =====
// Package with shared types and constants for the endstop actuator controller.
`timescale 1ns / 1ps

package eac_pkg;

    // Request codes carried in req_type.
    localparam logic [2:0] REQ_TICK    = 3'd0;
    localparam logic [2:0] REQ_TO_MIN  = 3'd1;
    localparam logic [2:0] REQ_TO_MAX  = 3'd2;
    localparam logic [2:0] REQ_STOP    = 3'd3;
    localparam logic [2:0] REQ_RESET   = 3'd4;

    // Configuration register indexes.
    localparam logic [2:0] CFG_DRIVE_MODE   = 3'd0;
    localparam logic [2:0] CFG_MIN_POL_HIGH = 3'd1;
    localparam logic [2:0] CFG_MAX_POL_HIGH = 3'd2;
    localparam logic [2:0] CFG_MIN_PRESENT  = 3'd3;
    localparam logic [2:0] CFG_MAX_PRESENT  = 3'd4;
    localparam logic [2:0] CFG_TIMEOUT      = 3'd5;

    localparam int          TICK_W       = 24;
    localparam logic [23:0] TICK_MAX     = 24'hFFFFFF;
    localparam logic [23:0] TIMEOUT_RST  = 24'd10000;

    // Read status codes.
    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_TIMEOUT = 2'd1;
    localparam logic [1:0] STATUS_BOTH    = 2'd2;

    // Event codes.
    localparam logic [1:0] EVENT_NONE    = 2'd0;
    localparam logic [1:0] EVENT_MIN     = 2'd1;
    localparam logic [1:0] EVENT_MAX     = 2'd2;
    localparam logic [1:0] EVENT_TIMEOUT = 2'd3;

    typedef enum logic [1:0] {
        MODE_IDLE   = 2'd0,
        MODE_TO_MIN = 2'd1,
        MODE_TO_MAX = 2'd2,
        MODE_FAULT  = 2'd3
    } motion_t;

    typedef enum logic [1:0] {
        LOC_MIN     = 2'd0,
        LOC_MAX     = 2'd1,
        LOC_UNKNOWN = 2'd2
    } loc_t;

    // Configuration registers as seen by the update logic.
    typedef struct packed {
        logic        drive_mode;
        logic        min_pol_high;
        logic        max_pol_high;
        logic        min_present;
        logic        max_present;
        logic [23:0] timeout_ticks;
    } cfg_t;

    // Controller state held across transactions.
    typedef struct packed {
        motion_t     mode;
        loc_t        latch;
        logic [23:0] elapsed;
    } state_t;

    // Result fields, first field in the highest bits.
    typedef struct packed {
        logic [1:0] event_res;
        logic       max_reached;
        logic       min_reached;
        logic [1:0] read_status;
        logic [1:0] position;
        logic [1:0] motion_state;
        logic       out_b;
        logic       out_a;
    } result_t;

endpackage

// ===== rtl/endstop_actuator_controller.sv =====
// Top level of the endstop actuator controller: stream ports, configuration and state registers.
`timescale 1ns / 1ps
// A result is registered and appears on the master side in the cycle after its transaction is accepted.
// Throughput: one transaction per cycle while the result side is not stalled; the state
// update is a single pass of logic into the state register and the result register.
// A result register parts the two sides: input is taken whenever it is empty or being drained.
// Reset (aresetn low, synchronous) sets configuration to defaults, state to idle with unknown
// position and a zero tick count, and empties the result register.

module endstop_actuator_controller
    import eac_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    // Configuration write port.
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [23:0] cfg_wdata,
    // Request stream.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [2:0] req_type, [3] min_level, [4] max_level, [7:5] zero
    // Result stream.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // [0] out_a, [1] out_b, [3:2] motion_state, [5:4] position,
                                   // [7:6] read_status, [8] min_reached, [9] max_reached,
                                   // [11:10] event_res, [15:12] zero
);

    cfg_t    cfg_reg;
    state_t  state_reg;
    state_t  state_next;
    result_t result_next;
    result_t result_reg;
    logic    m_tvalid_reg;
    logic    s_accept;

    assign s_tready = !m_tvalid_reg || m_tready;
    assign s_accept = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {4'b0000, result_reg};

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.drive_mode    <= 1'b0;
            cfg_reg.min_pol_high  <= 1'b1;
            cfg_reg.max_pol_high  <= 1'b1;
            cfg_reg.min_present   <= 1'b1;
            cfg_reg.max_present   <= 1'b1;
            cfg_reg.timeout_ticks <= TIMEOUT_RST;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_DRIVE_MODE:   cfg_reg.drive_mode    <= cfg_wdata[0];
                CFG_MIN_POL_HIGH: cfg_reg.min_pol_high  <= cfg_wdata[0];
                CFG_MAX_POL_HIGH: cfg_reg.max_pol_high  <= cfg_wdata[0];
                CFG_MIN_PRESENT:  cfg_reg.min_present   <= cfg_wdata[0];
                CFG_MAX_PRESENT:  cfg_reg.max_present   <= cfg_wdata[0];
                CFG_TIMEOUT:      cfg_reg.timeout_ticks <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // Update logic for one request.
    eac_step u_step (
        .cfg        (cfg_reg),
        .state      (state_reg),
        .req_type   (s_tdata[2:0]),
        .min_level  (s_tdata[3]),
        .max_level  (s_tdata[4]),
        .state_next (state_next),
        .result     (result_next)
    );

    // State register, advanced on each accepted transaction.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg.mode    <= MODE_IDLE;
            state_reg.latch   <= LOC_UNKNOWN;
            state_reg.elapsed <= '0;
        end else if (s_accept) begin
            state_reg <= state_next;
        end
    end

    // Result register and its valid flag.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (s_accept) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            result_reg <= result_next;
        end
    end

    // The tick count only runs while the actuator moves.
    a_idle_count_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg.mode == MODE_IDLE || state_reg.mode == MODE_FAULT) |->
            state_reg.elapsed == '0)
        else $error("tick count nonzero while not moving");

    // A latched end is only held while idle.
    a_latch_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg.latch != LOC_UNKNOWN |-> state_reg.mode == MODE_IDLE)
        else $error("position latched while moving or in fault");

    // A stalled result blocks new transactions.
    a_stall_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |-> !s_tready)
        else $error("input accepted while result stalled");

    // Any fault status reports an unknown position.
    a_fault_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[7:6] != STATUS_OK |-> m_tdata[5:4] == LOC_UNKNOWN)
        else $error("position reported under fault status");

endmodule

// ===== rtl/eac_step.sv =====
// Next-state and result logic for one request of the endstop actuator controller.
`timescale 1ns / 1ps

module eac_step
    import eac_pkg::*;
(
    input  cfg_t       cfg,
    input  state_t     state,
    input  logic [2:0] req_type,
    input  logic       min_level,
    input  logic       max_level,
    output state_t     state_next,
    output result_t    result
);

    logic        min_pin;
    logic        max_pin;
    logic        moving;
    logic [23:0] tick_plus;
    logic [23:0] tick_inc;
    logic        min_r;
    logic        max_r;
    logic [1:0]  status;
    logic [1:0]  event_code;

    // Endstop activity after presence and polarity.
    assign min_pin = cfg.min_present & (cfg.min_pol_high ? min_level : ~min_level);
    assign max_pin = cfg.max_present & (cfg.max_pol_high ? max_level : ~max_level);
    assign moving  = (state.mode == MODE_TO_MIN) || (state.mode == MODE_TO_MAX);

    // Saturating tick count.
    assign tick_plus = state.elapsed + 24'd1;
    assign tick_inc  = (state.elapsed == TICK_MAX) ? state.elapsed : tick_plus;

    // State update per request.
    always_comb begin
        state_next = state;
        event_code = EVENT_NONE;
        case (req_type)
            REQ_TICK: begin
                if (state.mode == MODE_TO_MIN && min_pin) begin
                    state_next.mode    = MODE_IDLE;
                    state_next.elapsed = '0;
                    state_next.latch   = LOC_MIN;
                    event_code         = EVENT_MIN;
                end else if (state.mode == MODE_TO_MAX && max_pin) begin
                    state_next.mode    = MODE_IDLE;
                    state_next.elapsed = '0;
                    state_next.latch   = LOC_MAX;
                    event_code         = EVENT_MAX;
                end else if (moving) begin
                    state_next.elapsed = tick_inc;
                    if (tick_inc > cfg.timeout_ticks) begin
                        state_next.elapsed = '0;
                        state_next.mode    = MODE_FAULT;
                        state_next.latch   = LOC_UNKNOWN;
                        event_code         = EVENT_TIMEOUT;
                    end
                end
            end
            REQ_TO_MIN: begin
                state_next.elapsed = '0;
                if (state.mode != MODE_FAULT) begin
                    state_next.mode = MODE_IDLE;
                end
                if (!(min_pin || state.latch == LOC_MIN)) begin
                    state_next.mode  = MODE_TO_MIN;
                    state_next.latch = LOC_UNKNOWN;
                end
            end
            REQ_TO_MAX: begin
                state_next.elapsed = '0;
                if (state.mode != MODE_FAULT) begin
                    state_next.mode = MODE_IDLE;
                end
                if (!(max_pin || state.latch == LOC_MAX)) begin
                    state_next.mode  = MODE_TO_MAX;
                    state_next.latch = LOC_UNKNOWN;
                end
            end
            REQ_STOP: begin
                state_next.elapsed = '0;
                if (state.mode != MODE_FAULT) begin
                    state_next.mode = MODE_IDLE;
                end
            end
            REQ_RESET: begin
                state_next.mode    = MODE_IDLE;
                state_next.latch   = LOC_UNKNOWN;
                state_next.elapsed = '0;
            end
            default: begin
                state_next = state;
            end
        endcase
    end

    // Result fields from the updated state.
    assign min_r = min_pin || (state_next.latch == LOC_MIN);
    assign max_r = max_pin || (state_next.latch == LOC_MAX);

    always_comb begin
        if (state_next.mode == MODE_FAULT) begin
            status = STATUS_TIMEOUT;
        end else if (min_r && max_r) begin
            status = STATUS_BOTH;
        end else begin
            status = STATUS_OK;
        end
    end

    always_comb begin
        result              = '0;
        result.motion_state = state_next.mode;
        result.read_status  = status;
        result.min_reached  = min_r;
        result.max_reached  = max_r;
        result.event_res    = event_code;
        if (status != STATUS_OK) begin
            result.position = LOC_UNKNOWN;
        end else if (min_r) begin
            result.position = LOC_MIN;
        end else if (max_r) begin
            result.position = LOC_MAX;
        end else begin
            result.position = state_next.latch;
        end
        // H-bridge drives one pin per direction; dir/enable uses a direction and an enable.
        if (!cfg.drive_mode) begin
            result.out_a = (state_next.mode == MODE_TO_MIN);
            result.out_b = (state_next.mode == MODE_TO_MAX);
        end else begin
            result.out_a = (state_next.mode == MODE_TO_MAX);
            result.out_b = (state_next.mode == MODE_TO_MIN) ||
                           (state_next.mode == MODE_TO_MAX);
        end
    end

endmodule

// ===== verif/eac_result_checker.sv =====
// Scoreboard for the endstop actuator controller: predicts every result and compares it.
`timescale 1ns / 1ps

module eac_result_checker
    import eac_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [23:0] cfg_wdata,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,   // [2:0] req_type, [3] min_level, [4] max_level, [7:5] zero
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [15:0] m_tdata,   // [0] out_a, [1] out_b, [3:2] motion_state, [5:4] position,
                                   // [7:6] read_status, [8] min_reached, [9] max_reached,
                                   // [11:10] event_res, [15:12] zero
    output int          errors,
    output int          outstanding
);

    // Shadow copy of the configuration registers.
    cfg_t        cfg;

    // Shadow copy of the controller state.
    motion_t     mode;
    loc_t        latch;
    logic [23:0] elapsed;

    // Results predicted but not yet seen on the master side.
    result_t     expected_results[$];

    result_t     want;
    result_t     got;
    string       diff;

    initial begin
        errors      = 0;
        outstanding = 0;
    end

    // Any command that ends motion keeps a fault but always clears the tick count.
    task automatic halt_drive();
        if (mode != MODE_FAULT) begin
            mode = MODE_IDLE;
        end
        elapsed = '0;
    endtask

    // Advances the shadow state by one request and returns the result it produces.
    task automatic advance_actuator(input logic [2:0] req, input logic min_lv,
                                    input logic max_lv, output result_t res);
        logic       min_act;
        logic       max_act;
        logic       min_hit;
        logic       max_hit;
        logic [1:0] ev;
        logic [1:0] status;
        logic [1:0] pos;

        // An active-high switch is active at level 1, an active-low one at level 0.
        min_act = cfg.min_present && (min_lv == cfg.min_pol_high);
        max_act = cfg.max_present && (max_lv == cfg.max_pol_high);
        ev      = EVENT_NONE;

        case (req)
            REQ_TICK: begin
                if (mode == MODE_TO_MIN && min_act) begin
                    mode    = MODE_IDLE;
                    elapsed = '0;
                    latch   = LOC_MIN;
                    ev      = EVENT_MIN;
                end else if (mode == MODE_TO_MAX && max_act) begin
                    mode    = MODE_IDLE;
                    elapsed = '0;
                    latch   = LOC_MAX;
                    ev      = EVENT_MAX;
                end else if (mode == MODE_TO_MIN || mode == MODE_TO_MAX) begin
                    // Saturating count; the fault fires once it passes the limit.
                    if (elapsed != TICK_MAX) begin
                        elapsed = elapsed + 24'd1;
                    end
                    if (elapsed > cfg.timeout_ticks) begin
                        elapsed = '0;
                        mode    = MODE_FAULT;
                        latch   = LOC_UNKNOWN;
                        ev      = EVENT_TIMEOUT;
                    end
                end
            end
            REQ_TO_MIN: begin
                halt_drive();
                if (!(min_act || latch == LOC_MIN)) begin
                    mode  = MODE_TO_MIN;
                    latch = LOC_UNKNOWN;
                end
            end
            REQ_TO_MAX: begin
                halt_drive();
                if (!(max_act || latch == LOC_MAX)) begin
                    mode  = MODE_TO_MAX;
                    latch = LOC_UNKNOWN;
                end
            end
            REQ_STOP: begin
                halt_drive();
            end
            REQ_RESET: begin
                mode  = MODE_IDLE;
                latch = LOC_UNKNOWN;
                halt_drive();
            end
            default: begin
            end
        endcase

        min_hit = min_act || latch == LOC_MIN;
        max_hit = max_act || latch == LOC_MAX;

        if (mode == MODE_FAULT) begin
            status = STATUS_TIMEOUT;
        end else if (min_hit && max_hit) begin
            status = STATUS_BOTH;
        end else begin
            status = STATUS_OK;
        end

        // Any fault hides the position.
        if (status != STATUS_OK) begin
            pos = LOC_UNKNOWN;
        end else if (min_hit) begin
            pos = LOC_MIN;
        end else if (max_hit) begin
            pos = LOC_MAX;
        end else begin
            pos = latch;
        end

        // Both drive pins stay low whenever the actuator is not moving.
        if (!cfg.drive_mode) begin
            res.out_a = (mode == MODE_TO_MIN);
            res.out_b = (mode == MODE_TO_MAX);
        end else begin
            res.out_a = (mode == MODE_TO_MAX);
            res.out_b = (mode == MODE_TO_MIN || mode == MODE_TO_MAX);
        end
        res.motion_state = mode;
        res.position     = pos;
        res.read_status  = status;
        res.min_reached  = min_hit;
        res.max_reached  = max_hit;
        res.event_res    = ev;
    endtask

    function automatic string show_result(input result_t r, input logic [3:0] pad);
        return $sformatf("a=%0d b=%0d state=%0d pos=%0d status=%0d min=%0d max=%0d event=%0d pad=%0h",
                         r.out_a, r.out_b, r.motion_state, r.position, r.read_status,
                         r.min_reached, r.max_reached, r.event_res, pad);
    endfunction

    // Track configuration, predict on each accepted request and check each accepted result.
    always @(posedge aclk) begin
        if (!aresetn) begin
            cfg.drive_mode    <= 1'b0;
            cfg.min_pol_high  <= 1'b1;
            cfg.max_pol_high  <= 1'b1;
            cfg.min_present   <= 1'b1;
            cfg.max_present   <= 1'b1;
            cfg.timeout_ticks <= TIMEOUT_RST;
            mode    = MODE_IDLE;
            latch   = LOC_UNKNOWN;
            elapsed = '0;
            expected_results.delete();
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    CFG_DRIVE_MODE:   cfg.drive_mode    <= cfg_wdata[0];
                    CFG_MIN_POL_HIGH: cfg.min_pol_high  <= cfg_wdata[0];
                    CFG_MAX_POL_HIGH: cfg.max_pol_high  <= cfg_wdata[0];
                    CFG_MIN_PRESENT:  cfg.min_present   <= cfg_wdata[0];
                    CFG_MAX_PRESENT:  cfg.max_present   <= cfg_wdata[0];
                    CFG_TIMEOUT:      cfg.timeout_ticks <= cfg_wdata;
                    default: begin
                    end
                endcase
            end

            // Result transaction: compare against the oldest prediction.
            if (m_tvalid && m_tready) begin
                got = result_t'(m_tdata[11:0]);
                if (expected_results.size() == 0) begin
                    if (errors < 10) begin
                        $display("unexpected result: %s", show_result(got, m_tdata[15:12]));
                    end
                    errors = errors + 1;
                end else begin
                    want = expected_results.pop_front();
                    diff = "";
                    if (got.out_a != want.out_a)               diff = {diff, " out_a"};
                    if (got.out_b != want.out_b)               diff = {diff, " out_b"};
                    if (got.motion_state != want.motion_state) diff = {diff, " motion_state"};
                    if (got.position != want.position)         diff = {diff, " position"};
                    if (got.read_status != want.read_status)   diff = {diff, " read_status"};
                    if (got.min_reached != want.min_reached)   diff = {diff, " min_reached"};
                    if (got.max_reached != want.max_reached)   diff = {diff, " max_reached"};
                    if (got.event_res != want.event_res)       diff = {diff, " event_res"};
                    if (m_tdata[15:12] != 4'd0)                diff = {diff, " padding"};
                    if (diff != "") begin
                        if (errors < 10) begin
                            $display("mismatch in%s at %0t", diff, $realtime);
                            $display("  expected %s", show_result(want, 4'd0));
                            $display("  actual   %s", show_result(got, m_tdata[15:12]));
                        end
                        errors = errors + 1;
                    end
                end
            end

            // Request transaction: predict its result.
            if (s_tvalid && s_tready) begin
                advance_actuator(s_tdata[2:0], s_tdata[3], s_tdata[4], want);
                expected_results.push_back(want);
            end
        end
        outstanding <= expected_results.size();
    end

endmodule

// ===== verif/tb_endstop_actuator_controller.sv =====
// Testbench top for the endstop actuator controller: stimulus, stalls and the verdict.
`timescale 1ns / 1ps

module tb_endstop_actuator_controller;
    import eac_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASE_ITEMS = 130;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        cfg_we    = 1'b0;
    logic [2:0]  cfg_index = CFG_DRIVE_MODE;
    logic [23:0] cfg_wdata = '0;
    logic        s_tvalid  = 1'b0;
    logic [7:0]  s_tdata   = '0;   // [2:0] req_type, [3] min_level, [4] max_level, [7:5] zero
    logic        m_tready  = 1'b1;
    wire         s_tready;
    wire         m_tvalid;
    wire  [15:0] m_tdata;          // [0] out_a, [1] out_b, [3:2] motion_state, [5:4] position,
                                   // [7:6] read_status, [8] min_reached, [9] max_reached,
                                   // [11:10] event_res, [15:12] zero
    int          errors;
    int          outstanding;

    // Settings currently programmed, used to steer the endstop levels.
    logic        min_pol_now   = 1'b1;
    logic        max_pol_now   = 1'b1;
    logic [23:0] timeout_now   = TIMEOUT_RST;

    int          accepted      = 0;
    int          burst_left    = 1;
    int          cycles        = 0;
    int          stall_left    = 0;
    int          stall_mode    = 0;

    endstop_actuator_controller DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    eac_result_checker scoreboard (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .errors      (errors),
        .outstanding (outstanding)
    );

    initial begin
        forever #10 aclk = ~aclk;
    end

    // Watchdog on the whole run.
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // Result side backpressure: the pattern is redrawn whenever its countdown runs out.
    always @(posedge aclk) begin
        if (stall_left == 0) begin
            stall_mode <= $urandom_range(0, 3);
            stall_left <= $urandom_range(16, 96);
        end else begin
            stall_left <= stall_left - 1;
        end
        case (stall_mode)
            0: m_tready <= 1'b1;
            1: m_tready <= ($urandom_range(0, 3) != 0);
            2: m_tready <= (stall_left % 3 == 0);
            default: m_tready <= 1'($urandom_range(0, 1));
        endcase
    end

    // Sends one request and returns once its transaction is accepted; may idle between bursts.
    task automatic send_request(input logic [2:0] req, input logic min_lv, input logic max_lv);
        int gap;
        s_tvalid <= 1'b1;
        s_tdata  <= {3'b000, max_lv, min_lv, req};
        do @(posedge aclk); while (!s_tready);
        accepted   = accepted + 1;
        burst_left = burst_left - 1;
        if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 16);
            gap        = $urandom_range(0, 5);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
    endtask

    // Lets the block drain so the registers can be rewritten while it is idle.
    task automatic drain();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (outstanding != 0);
        repeat (3) @(posedge aclk);
    endtask

    // Writes all six registers, one per clock.
    task automatic apply_settings(input logic dmode, input logic min_pol, input logic max_pol,
                                  input logic min_pres, input logic max_pres,
                                  input logic [23:0] tmo);
        logic [2:0]  idx [6];
        logic [23:0] val [6];
        int i;
        idx = '{CFG_DRIVE_MODE, CFG_MIN_POL_HIGH, CFG_MAX_POL_HIGH,
                CFG_MIN_PRESENT, CFG_MAX_PRESENT, CFG_TIMEOUT};
        val = '{{23'd0, dmode}, {23'd0, min_pol}, {23'd0, max_pol},
                {23'd0, min_pres}, {23'd0, max_pres}, tmo};
        for (i = 0; i < 6; i++) begin
            cfg_we    <= 1'b1;
            cfg_index <= idx[i];
            cfg_wdata <= val[i];
            @(posedge aclk);
        end
        cfg_we      <= 1'b0;
        min_pol_now = min_pol;
        max_pol_now = max_pol;
        timeout_now = tmo;
    endtask

    // A drive command followed by ticks with the target switch clear, usually ending on it.
    task automatic play_motion();
        logic to_max;
        logic act_lvl;
        int   ticks;
        int   i;
        to_max  = 1'($urandom_range(0, 1));
        act_lvl = to_max ? max_pol_now : min_pol_now;
        if (to_max) begin
            send_request(REQ_TO_MAX, 1'($urandom_range(0, 1)),
                         ($urandom_range(0, 7) == 0) ? act_lvl : ~act_lvl);
        end else begin
            send_request(REQ_TO_MIN, ($urandom_range(0, 7) == 0) ? act_lvl : ~act_lvl,
                         1'($urandom_range(0, 1)));
        end
        ticks = (timeout_now <= 24'd12) ? $urandom_range(0, int'(timeout_now) + 2)
                                        : $urandom_range(0, 14);
        for (i = 0; i < ticks; i++) begin
            if ($urandom_range(0, 19) == 0) begin
                send_request(3'($urandom_range(1, 7)), 1'($urandom_range(0, 1)),
                             1'($urandom_range(0, 1)));
            end else if (to_max) begin
                send_request(REQ_TICK, 1'($urandom_range(0, 1)), ~act_lvl);
            end else begin
                send_request(REQ_TICK, ~act_lvl, 1'($urandom_range(0, 1)));
            end
        end
        if ($urandom_range(0, 3) != 0) begin
            if (to_max) begin
                send_request(REQ_TICK, 1'($urandom_range(0, 1)), act_lvl);
            end else begin
                send_request(REQ_TICK, act_lvl, 1'($urandom_range(0, 1)));
            end
        end
    endtask

    // Mostly well-formed motion, with bursts of arbitrary requests mixed in.
    task automatic run_phase(input int quota);
        int start;
        start = accepted;
        while (accepted - start < quota) begin
            if ($urandom_range(0, 4) == 0) begin
                repeat ($urandom_range(1, 4)) begin
                    send_request(3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)),
                                 1'($urandom_range(0, 1)));
                end
            end else begin
                play_motion();
            end
        end
        drain();
    endtask

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed walk at a limit of one tick: reach, latch, timeout, fault exits, unused codes.
        apply_settings(1'b0, 1'b1, 1'b1, 1'b1, 1'b1, 24'd1);
        send_request(REQ_TICK,   1'b0, 1'b0);
        send_request(REQ_TO_MAX, 1'b0, 1'b0);
        send_request(REQ_STOP,   1'b0, 1'b1);
        send_request(REQ_TO_MAX, 1'b0, 1'b1);
        send_request(REQ_TO_MAX, 1'b0, 1'b0);
        send_request(REQ_TICK,   1'b0, 1'b1);
        send_request(REQ_TO_MAX, 1'b0, 1'b0);
        send_request(REQ_TO_MIN, 1'b0, 1'b0);
        send_request(REQ_TICK,   1'b0, 1'b0);
        send_request(REQ_TICK,   1'b0, 1'b0);
        send_request(REQ_STOP,   1'b1, 1'b1);
        send_request(REQ_RESET,  1'b0, 1'b0);
        send_request(REQ_TO_MIN, 1'b0, 1'b0);
        send_request(REQ_TO_MAX, 1'b1, 1'b0);
        send_request(REQ_TICK,   1'b1, 1'b0);
        send_request(REQ_TICK,   1'b0, 1'b1);
        send_request(REQ_TICK,   1'b1, 1'b1);
        send_request(3'd5,       1'b1, 1'b1);
        send_request(3'd6,       1'b0, 1'b0);
        send_request(3'd7,       1'b1, 1'b0);
        send_request(REQ_TO_MIN, 1'b0, 1'b0);
        send_request(REQ_TICK,   1'b0, 1'b0);
        send_request(REQ_TICK,   1'b0, 1'b0);
        send_request(REQ_TO_MAX, 1'b0, 1'b0);
        send_request(REQ_TICK,   1'b1, 1'b1);
        drain();

        // Random phases across drive modes, polarities, missing switches and limits.
        apply_settings(1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 24'd3);
        run_phase(PHASE_ITEMS);
        apply_settings(1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 24'd0);
        run_phase(PHASE_ITEMS);
        apply_settings(1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 24'd5);
        run_phase(PHASE_ITEMS);
        apply_settings(1'b0, 1'b1, 1'b0, 1'b1, 1'b0, TICK_MAX);
        run_phase(PHASE_ITEMS);
        apply_settings(1'b1, 1'b1, 1'b1, 1'b1, 1'b1, TIMEOUT_RST);
        run_phase(PHASE_ITEMS);
        apply_settings(1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 24'd2);
        run_phase(PHASE_ITEMS);
        repeat (2) begin
            apply_settings(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                           1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                           1'($urandom_range(0, 1)), 24'($urandom_range(0, 8)));
            run_phase(PHASE_ITEMS);
        end

        if (errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/eac_pkg.sv
rtl/eac_step.sv
rtl/endstop_actuator_controller.sv
verif/eac_result_checker.sv
verif/tb_endstop_actuator_controller.sv
